### src/assert_macros.svh
// Assertion macros used by the encoder pulser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a condition that must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, (1'b1 |-> (cond)), msg)

`endif

### src/epu_pkg.sv
// Package with the types, constants and helpers of the encoder pulser.
`timescale 1ns / 1ps

package epu_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int STEP_CAP    = 50;

	localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int ENTRY_W = 3;
	localparam int STEP_W  = 6;
	localparam int BTN_W   = 8;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 20;
	localparam int THR_W   = CFG_W + 1;

	localparam logic [1:0] CMD_REGISTER = 2'd0;
	localparam logic [1:0] CMD_ADD      = 2'd1;
	localparam logic [1:0] CMD_PROCESS  = 2'd2;
	localparam logic [1:0] CMD_CLEAR    = 2'd3;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_CW   = 2'd1;
	localparam logic [1:0] DIR_CCW  = 2'd2;

	localparam logic REG_DURATION = 1'b0;
	localparam logic REG_INTERVAL = 1'b1;

	localparam logic KIND_REPLY = 1'b0;
	localparam logic KIND_EVENT = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [ENTRY_W-1:0] idx;
		logic               ok;
		logic [BTN_W-1:0]   button;
		logic               level;
	} epu_rec_t;

	typedef struct packed {
		logic     push;
		logic     flush;
		epu_rec_t rec;
	} epu_out_ctl_t;

	function automatic logic [BTN_W-1:0] joy_index(input logic [BTN_W-1:0] button);
		logic [BTN_W-1:0] res;
		res = (button == '0) ? '0 : button - BTN_W'(1);
		return res;
	endfunction

endpackage

### src/epu_alu.sv
// Shared arithmetic unit: elapsed-time compare and saturating step add.
`timescale 1ns / 1ps

module epu_alu
	import epu_pkg::*;
(
	input  logic [TIME_W-1:0] now,
	input  logic [TIME_W-1:0] press_time,
	input  logic [THR_W-1:0]  threshold,
	input  logic [STEP_W-1:0] have,
	input  logic [BTN_W-1:0]  add,
	output logic              elapsed_ge,
	output logic [STEP_W-1:0] sat_sum
);

	logic [TIME_W-1:0]  elapsed;
	logic [STEP_W+2:0]  sum;

	// Elapsed time wraps modulo 2^32, as the time base does.
	assign elapsed    = now - press_time;
	assign elapsed_ge = elapsed >= TIME_W'(threshold);

	assign sum = (STEP_W + 3)'(have) + (STEP_W + 3)'(add);

	always_comb begin
		if (have >= STEP_W'(STEP_CAP)) begin
			sat_sum = have;
		end else if (sum > (STEP_W + 3)'(STEP_CAP)) begin
			sat_sum = STEP_W'(STEP_CAP);
		end else begin
			sat_sum = sum[STEP_W-1:0];
		end
	end

endmodule

### src/epu_out_stage.sv
// Output stage: holds one result back so that the final word can be marked.
`timescale 1ns / 1ps

module epu_out_stage
	import epu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  epu_out_ctl_t       ctl,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [ENTRY_W-1:0] entry_index,
	output logic               entry_ok,
	output logic [BTN_W-1:0]   joystick_button,
	output logic               button_level,
	output logic               last
);

	epu_rec_t hold_q;
	logic     hold_v_q;
	epu_rec_t out_q;
	logic     out_v_q;
	logic     last_q;
	logic     out_free;
	logic     load_push;
	logic     load_flush;

	assign out_free   = !out_v_q || out_ready;
	assign room       = !hold_v_q || out_free;
	// A new word pushes the held one out, which is then known not to be final.
	assign load_push  = ctl.push && room && hold_v_q;
	assign load_flush = ctl.flush && !ctl.push && hold_v_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (ctl.push && room) begin
				hold_v_q <= 1'b1;
			end else if (load_flush) begin
				hold_v_q <= 1'b0;
			end
			if (load_push || load_flush) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && room) begin
			hold_q <= ctl.rec;
		end
		if (load_push || load_flush) begin
			out_q  <= hold_q;
			last_q <= load_flush;
		end
	end

	assign out_valid       = out_v_q;
	assign result_kind     = out_q.kind;
	assign entry_index     = out_q.idx;
	assign entry_ok        = out_q.ok;
	assign joystick_button = out_q.button;
	assign button_level    = out_q.level;
	assign last            = last_q;

endmodule

### src/encoder_step_to_button_pulser_unit.sv
// Register pushes its reply, which the flush state sends marked last. Add searches entry
// by entry up to a match or the last entry; process visits a release and then a press
// state per entry, since the shared compare unit checks release and then press for each
// entry; clear, and add or process on an empty table, stay idle. One command is in flight
// at a time, and output back-pressure stretches register and process commands only.
// Reset empties the table and loads 50000 us into duration and interval.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module encoder_step_to_button_pulser_unit
	import epu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [BTN_W-1:0]   cw_button,
	input  logic [BTN_W-1:0]   ccw_button,
	input  logic [BTN_W-1:0]   step_button,
	input  logic [BTN_W-1:0]   step_count,
	input  logic [TIME_W-1:0]  now_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [ENTRY_W-1:0] entry_index,
	output logic               entry_ok,
	output logic [BTN_W-1:0]   joystick_button,
	output logic               button_level,
	output logic               last
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_REG   = 3'd1;
	localparam logic [2:0] S_ADD   = 3'd2;
	localparam logic [2:0] S_REL   = 3'd3;
	localparam logic [2:0] S_PRESS = 3'd4;
	localparam logic [2:0] S_FLUSH = 3'd5;

	logic [2:0]        state_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [CFG_W-1:0]  dur_q;
	logic [CFG_W-1:0]  int_q;

	logic [BTN_W-1:0]  cwb_q;
	logic [BTN_W-1:0]  ccwb_q;
	logic [BTN_W-1:0]  sbtn_q;
	logic [BTN_W-1:0]  scnt_q;
	logic [TIME_W-1:0] now_q;

	logic [BTN_W-1:0]  cw_id_q   [MAX_ENTRIES];
	logic [BTN_W-1:0]  ccw_id_q  [MAX_ENTRIES];
	logic [STEP_W-1:0] pcw_q     [MAX_ENTRIES];
	logic [STEP_W-1:0] pccw_q    [MAX_ENTRIES];
	logic [TIME_W-1:0] ptime_q   [MAX_ENTRIES];
	logic              pressed_q [MAX_ENTRIES];
	logic [1:0]        dir_q     [MAX_ENTRIES];

	logic [BTN_W-1:0]  cur_cw;
	logic [BTN_W-1:0]  cur_ccw;
	logic [STEP_W-1:0] cur_pcw;
	logic [STEP_W-1:0] cur_pccw;
	logic              cur_pressed;
	logic [1:0]        cur_dir;
	logic [1:0]        next_dir;
	logic              in_acc;
	logic              last_entry;
	logic              table_full;
	logic              match_cw;
	logic              match_ccw;
	logic [THR_W-1:0]  threshold;
	logic              elapsed_ge;
	logic [STEP_W-1:0] sat_sum;
	logic              rel_fire;
	logic              press_fire;
	logic              room;
	epu_out_ctl_t      octl;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;

	assign cur_cw      = cw_id_q[ptr_q];
	assign cur_ccw     = ccw_id_q[ptr_q];
	assign cur_pcw     = pcw_q[ptr_q];
	assign cur_pccw    = pccw_q[ptr_q];
	assign cur_pressed = pressed_q[ptr_q];
	assign cur_dir     = dir_q[ptr_q];

	assign last_entry = (CNT_W'(ptr_q) + CNT_W'(1)) == count_q;
	assign table_full = count_q >= CNT_W'(MAX_ENTRIES);
	assign match_cw   = (cur_cw == sbtn_q);
	assign match_ccw  = (cur_ccw == sbtn_q);

	// The release check uses the duration; the same-direction press check uses
	// duration plus interval, both against the time since the last press.
	assign threshold = (state_q == S_REL) ? THR_W'(dur_q)
	                                      : THR_W'(dur_q) + THR_W'(int_q);

	epu_alu u_alu (
		.now        (now_q),
		.press_time (ptime_q[ptr_q]),
		.threshold  (threshold),
		.have       (match_cw ? cur_pcw : cur_pccw),
		.add        (scnt_q),
		.elapsed_ge (elapsed_ge),
		.sat_sum    (sat_sum)
	);

	always_comb begin
		if (cur_dir == DIR_CW && cur_pcw != '0) begin
			next_dir = DIR_CW;
		end else if (cur_dir == DIR_CCW && cur_pccw != '0) begin
			next_dir = DIR_CCW;
		end else if (cur_pcw != '0) begin
			next_dir = DIR_CW;
		end else begin
			next_dir = DIR_CCW;
		end
	end

	assign rel_fire   = (state_q == S_REL) && cur_pressed && elapsed_ge;
	assign press_fire = (state_q == S_PRESS) && !cur_pressed
	                    && (cur_pcw != '0 || cur_pccw != '0)
	                    && (next_dir != cur_dir || elapsed_ge);

	always_comb begin
		octl.push       = 1'b0;
		octl.flush      = (state_q == S_FLUSH);
		octl.rec.kind   = KIND_EVENT;
		octl.rec.idx    = ENTRY_W'(ptr_q);
		octl.rec.ok     = 1'b0;
		octl.rec.button = '0;
		octl.rec.level  = 1'b0;
		unique case (state_q)
			S_REG: begin
				octl.push     = 1'b1;
				octl.rec.kind = KIND_REPLY;
				octl.rec.idx  = table_full ? '0 : ENTRY_W'(count_q);
				octl.rec.ok   = !table_full;
			end
			S_REL: begin
				octl.push       = rel_fire;
				octl.rec.button = joy_index((cur_dir == DIR_CW) ? cur_cw : cur_ccw);
			end
			S_PRESS: begin
				octl.push       = press_fire;
				octl.rec.level  = 1'b1;
				octl.rec.button = joy_index((next_dir == DIR_CW) ? cur_cw : cur_ccw);
			end
			default: begin
			end
		endcase
	end

	epu_out_stage u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (octl),
		.room            (room),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_kind     (result_kind),
		.entry_index     (entry_index),
		.entry_ok        (entry_ok),
		.joystick_button (joystick_button),
		.button_level    (button_level),
		.last            (last)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
			count_q <= '0;
			dur_q   <= CFG_W'(50000);
			int_q   <= CFG_W'(50000);
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DURATION) begin
					dur_q <= cfg_data;
				end
				if (cfg_index == REG_INTERVAL) begin
					int_q <= cfg_data;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					ptr_q <= '0;
					if (in_acc) begin
						unique case (cmd)
							CMD_REGISTER: state_q <= S_REG;
							CMD_ADD:      state_q <= (count_q == '0) ? S_IDLE : S_ADD;
							CMD_PROCESS:  state_q <= (count_q == '0) ? S_IDLE : S_REL;
							CMD_CLEAR:    count_q <= '0;
							default:      state_q <= S_IDLE;
						endcase
					end
				end
				S_REG: begin
					if (room) begin
						if (!table_full) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= S_FLUSH;
					end
				end
				S_ADD: begin
					if (match_cw || match_ccw || last_entry) begin
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + IDX_W'(1);
					end
				end
				S_REL: begin
					if (!rel_fire || room) begin
						state_q <= S_PRESS;
					end
				end
				S_PRESS: begin
					if (!press_fire || room) begin
						if (last_entry) begin
							state_q <= S_FLUSH;
						end else begin
							ptr_q   <= ptr_q + IDX_W'(1);
							state_q <= S_REL;
						end
					end
				end
				S_FLUSH: begin
					if (room) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command word and table contents; entries beyond the count are never read.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cwb_q  <= cw_button;
			ccwb_q <= ccw_button;
			sbtn_q <= step_button;
			scnt_q <= step_count;
			now_q  <= now_us;
		end
		if (state_q == S_REG && room && !table_full) begin
			cw_id_q[count_q[IDX_W-1:0]]   <= cwb_q;
			ccw_id_q[count_q[IDX_W-1:0]]  <= ccwb_q;
			pcw_q[count_q[IDX_W-1:0]]     <= '0;
			pccw_q[count_q[IDX_W-1:0]]    <= '0;
			ptime_q[count_q[IDX_W-1:0]]   <= '0;
			pressed_q[count_q[IDX_W-1:0]] <= 1'b0;
			dir_q[count_q[IDX_W-1:0]]     <= DIR_NONE;
		end
		if (state_q == S_ADD) begin
			if (match_cw) begin
				pcw_q[ptr_q] <= sat_sum;
			end else if (match_ccw) begin
				pccw_q[ptr_q] <= sat_sum;
			end
		end
		if (rel_fire && room) begin
			pressed_q[ptr_q] <= 1'b0;
		end
		if (press_fire && room) begin
			pressed_q[ptr_q] <= 1'b1;
			ptime_q[ptr_q]   <= now_q;
			dir_q[ptr_q]     <= next_dir;
			if (next_dir == DIR_CW) begin
				pcw_q[ptr_q] <= cur_pcw - STEP_W'(1);
			end else begin
				pccw_q[ptr_q] <= cur_pccw - STEP_W'(1);
			end
		end
	end

	`ASSERT_ALWAYS(a_count_in_range, clk, arst_n, count_q <= CNT_W'(MAX_ENTRIES), "entry count beyond table size")
	`ASSERT_CLK(a_busy_after_accept, clk, arst_n, in_valid && in_ready && cmd != CMD_CLEAR |=> !in_ready || count_q == '0, "sequencer took a command but stayed idle")
	`ASSERT_CLK(a_walk_in_table, clk, arst_n, state_q == S_REL || state_q == S_PRESS |-> CNT_W'(ptr_q) < count_q, "table walk beyond entry count")

endmodule
